// ===== hdl/rfcc_pkg.sv =====
// rfcc_pkg: shared constants and result type for the record field count checker
package rfcc_pkg;

    localparam logic [7:0] BAR_CHAR   = 8'h7C;
    localparam logic [7:0] DIGIT_ZERO = 8'h30;
    localparam logic [7:0] DIGIT_NINE = 8'h39;

    localparam int KEY_FIELD_OFFSET = 6;
    localparam int SEP_EXTRA        = 7;
    localparam int OUT_WIDTH        = 16;

    typedef struct packed {
        logic                 line_bad;
        logic [OUT_WIDTH-1:0] line_number;
        logic [OUT_WIDTH-1:0] error_total;
    } result_t;

endpackage

// ===== hdl/record_field_count_checker_unit.sv =====
// record_field_count_checker_unit: per-byte record line checker with result skid stage
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------
//  in      | input     | in_valid / in_stall  | data_byte, line_end
//  out     | output    | out_valid / out_stall| line_bad, line_number, error_total
//
//  one byte is accepted per cycle while in_stall is low; the line counters update in the same cycle
//  a line end result is registered into the output register, or into the skid stage while the output is stalled
//  rst_n clears all counters and flags asynchronously; no clearing pass
//  a held output result plus one result in the skid stage are buffered;
//  in_stall rises only while the skid stage is full
module record_field_count_checker_unit #(
    parameter int COUNT_WIDTH       = 8,
    parameter int LINE_NUMBER_WIDTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [7:0]                     data_byte,
    input  logic                           line_end,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           line_bad,
    output logic [rfcc_pkg::OUT_WIDTH-1:0] line_number,
    output logic [rfcc_pkg::OUT_WIDTH-1:0] error_total
);

    import rfcc_pkg::*;

    localparam int SEP_WIDTH = COUNT_WIDTH + 2;
    localparam int MUL_WIDTH = COUNT_WIDTH + 4;

    logic [SEP_WIDTH-1:0]         sep_count_reg, sep_count_next;
    logic [COUNT_WIDTH-1:0]       author_count_reg, author_count_next;
    logic [COUNT_WIDTH-1:0]       key_count_reg, key_count_next;
    logic                         in_leading_reg, in_leading_next;
    logic                         prev_sep_reg, prev_sep_next;
    logic [1:0]                   after_last_reg, after_last_next;
    logic                         line_failed_reg, line_failed_next;
    logic [LINE_NUMBER_WIDTH-1:0] lines_seen_reg, lines_seen_next;
    logic [OUT_WIDTH-1:0]         failures_reg, failures_next;

    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;
    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;

    logic                         accept;
    logic                         is_bar;
    logic                         is_digit;
    logic [3:0]                   digit_value;
    logic [MUL_WIDTH-1:0]         author_mul;
    logic [MUL_WIDTH-1:0]         key_mul;
    logic                         author_ovf;
    logic                         key_ovf;
    logic                         key_field;
    logic [SEP_WIDTH-1:0]         target;
    logic                         bad;
    logic                         new_result;
    logic [LINE_NUMBER_WIDTH+OUT_WIDTH-1:0] lines_wide;
    result_t                      result;

    assign accept      = in_valid && !in_stall;
    assign is_bar      = (data_byte == BAR_CHAR);
    assign is_digit    = (data_byte >= DIGIT_ZERO) && (data_byte <= DIGIT_NINE);
    assign digit_value = data_byte[3:0];

    assign author_mul = (MUL_WIDTH'(author_count_reg) << 3) + (MUL_WIDTH'(author_count_reg) << 1)
                        + MUL_WIDTH'(digit_value);
    assign key_mul    = (MUL_WIDTH'(key_count_reg) << 3) + (MUL_WIDTH'(key_count_reg) << 1)
                        + MUL_WIDTH'(digit_value);
    assign author_ovf = (author_mul[MUL_WIDTH-1:COUNT_WIDTH] != '0);
    assign key_ovf    = (key_mul[MUL_WIDTH-1:COUNT_WIDTH] != '0);
    assign key_field  = (sep_count_reg ==
                         SEP_WIDTH'(author_count_reg) + SEP_WIDTH'(KEY_FIELD_OFFSET));

    // per-byte field tracking
    always_comb
    begin
        sep_count_next    = sep_count_reg;
        author_count_next = author_count_reg;
        key_count_next    = key_count_reg;
        in_leading_next   = in_leading_reg;
        prev_sep_next     = prev_sep_reg;
        after_last_next   = after_last_reg;
        line_failed_next  = line_failed_reg;
        if (is_bar)
        begin
            if (prev_sep_reg)
            begin
                line_failed_next = 1'b1;
            end
            in_leading_next = 1'b0;
            if (sep_count_reg != '1)
            begin
                sep_count_next = sep_count_reg + 1'b1;
            end
            after_last_next = 2'd0;
            prev_sep_next   = 1'b1;
        end
        else
        begin
            prev_sep_next = 1'b0;
            if (in_leading_reg)
            begin
                if (is_digit)
                begin
                    if (author_ovf)
                    begin
                        line_failed_next  = 1'b1;
                        author_count_next = '1;
                    end
                    else
                    begin
                        author_count_next = author_mul[COUNT_WIDTH-1:0];
                    end
                end
                else
                begin
                    in_leading_next = 1'b0;
                end
            end
            else if (is_digit && key_field)
            begin
                if (key_ovf)
                begin
                    line_failed_next = 1'b1;
                    key_count_next   = '1;
                end
                else
                begin
                    key_count_next = key_mul[COUNT_WIDTH-1:0];
                end
            end
            if (after_last_reg != 2'd3)
            begin
                after_last_next = after_last_reg + 2'd1;
            end
        end
    end

    assign target = SEP_WIDTH'(author_count_next) + SEP_WIDTH'(key_count_next)
                    + SEP_WIDTH'(SEP_EXTRA);
    assign bad    = line_failed_next || (sep_count_next != target) || (after_last_next != 2'd1);
    assign new_result = accept && line_end;

    assign failures_next = (bad && failures_reg != '1) ? failures_reg + 1'b1 : failures_reg;
    assign lines_seen_next = lines_seen_reg + 1'b1;
    assign lines_wide      = (LINE_NUMBER_WIDTH + OUT_WIDTH)'(lines_seen_reg);

    assign result.line_bad    = bad;
    assign result.line_number = lines_wide[OUT_WIDTH-1:0];
    assign result.error_total = failures_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_count_reg    <= '0;
            author_count_reg <= '0;
            key_count_reg    <= '0;
            in_leading_reg   <= 1'b1;
            prev_sep_reg     <= 1'b0;
            after_last_reg   <= 2'd0;
            line_failed_reg  <= 1'b0;
            lines_seen_reg   <= '0;
            failures_reg     <= '0;
        end
        else if (accept)
        begin
            if (line_end)
            begin
                sep_count_reg    <= '0;
                author_count_reg <= '0;
                key_count_reg    <= '0;
                in_leading_reg   <= 1'b1;
                prev_sep_reg     <= 1'b0;
                after_last_reg   <= 2'd0;
                line_failed_reg  <= 1'b0;
                lines_seen_reg   <= lines_seen_next;
                failures_reg     <= failures_next;
            end
            else
            begin
                sep_count_reg    <= sep_count_next;
                author_count_reg <= author_count_next;
                key_count_reg    <= key_count_next;
                in_leading_reg   <= in_leading_next;
                prev_sep_reg     <= prev_sep_next;
                after_last_reg   <= after_last_next;
                line_failed_reg  <= line_failed_next;
            end
        end
    end

    // output register with one skid entry
    always_comb
    begin
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            if (skid_valid_reg)
            begin
                out_data_next = skid_data_reg;
                if (new_result)
                begin
                    skid_data_next = result;
                end
                else
                begin
                    skid_valid_next = 1'b0;
                end
            end
            else
            begin
                out_data_next  = result;
                out_valid_next = new_result;
            end
        end
        else if (!out_valid_reg)
        begin
            out_data_next  = result;
            out_valid_next = new_result;
        end
        else if (new_result)
        begin
            skid_data_next  = result;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign in_stall    = skid_valid_reg;
    assign out_valid   = out_valid_reg;
    assign line_bad    = out_data_reg.line_bad;
    assign line_number = out_data_reg.line_number;
    assign error_total = out_data_reg.error_total;

endmodule

// ===== hdl/rfcc_checker.sv =====
// rfcc_checker: port-level assertions for the record field count checker, with bind
module rfcc_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_stall,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic                           line_bad,
    input logic [rfcc_pkg::OUT_WIDTH-1:0] line_number,
    input logic [rfcc_pkg::OUT_WIDTH-1:0] error_total
);

    import rfcc_pkg::*;

    // input side only backs up behind a held result
    a_stall_needs_output: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("in_stall without a pending item");

    a_stall_after_out_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(out_valid && out_stall))
        else $error("in_stall rose without an output stall");

    a_bad_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && line_bad) |-> (error_total != '0))
        else $error("failed line with zero error total");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(line_bad)
            && $stable(line_number) && $stable(error_total)))
        else $error("stalled output item changed");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_stall) |=> in_valid)
        else $error("stalled input item withdrawn");

endmodule

bind record_field_count_checker_unit rfcc_checker u_rfcc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .line_bad    (line_bad),
    .line_number (line_number),
    .error_total (error_total)
);
